// ----- rtl/pose_frame_transform_top_macros.svh -----
// ----------------------------------------------------------------------------
// pose frame transform assertion macros
// shared concurrent assertion forms used by the rtl files
// ----------------------------------------------------------------------------
`ifndef POSE_FRAME_TRANSFORM_TOP_MACROS_SVH
`define POSE_FRAME_TRANSFORM_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define PFT_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define PFT_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ----- rtl/pft_pkg.sv -----
// ----------------------------------------------------------------------------
// pft_pkg
// types, constants and fixed point helpers of the pose frame transform
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pft_pkg;

    localparam int WORD_W  = 32;
    localparam int QFRAC   = WORD_W - 2;
    localparam int PROD_W  = WORD_W + 2;
    localparam int SUM_W   = WORD_W + 6;
    localparam int NUM_REGS = 7;
    localparam int ADDR_W  = 5;
    localparam int NORM_W  = WORD_W + 3;
    localparam int DVD_W   = WORD_W + QFRAC;
    localparam int CNT_W   = 6;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    typedef enum logic [2:0] {
        REG_POS_X  = 3'd0,
        REG_POS_Y  = 3'd1,
        REG_POS_Z  = 3'd2,
        REG_QUAT_X = 3'd3,
        REG_QUAT_Y = 3'd4,
        REG_QUAT_Z = 3'd5,
        REG_QUAT_W = 3'd6
    } reg_idx_t;

    localparam word_t QUAT_ONE = word_t'(64'sd1 <<< QFRAC);
    localparam sum_t  SAT_HI   = sum_t'(64'sd2147483647);
    localparam sum_t  SAT_LO   = sum_t'(-64'sd2147483648);

    typedef struct packed {
        word_t pos_x;
        word_t pos_y;
        word_t pos_z;
        word_t quat_x;
        word_t quat_y;
        word_t quat_z;
        word_t quat_w;
    } ref_t;

    typedef struct packed {
        logic  busy;
        logic  ovf;
        word_t x;
        word_t y;
        word_t z;
        word_t w;
    } inv_t;

    // product rounded to nearest, ties toward +inf
    function automatic prod_t rmul(input word_t a, input word_t b);
        logic signed [2*WORD_W-1:0] p;
        logic signed [2*WORD_W-1:0] s;
        p = a * b;
        s = p + (64'sd1 <<< (QFRAC - 1));
        return prod_t'(s[2*WORD_W-1:QFRAC]);
    endfunction

    function automatic word_t sat_word(input sum_t v);
        if (v > SAT_HI)
            return word_t'(SAT_HI[WORD_W-1:0]);
        else if (v < SAT_LO)
            return word_t'(SAT_LO[WORD_W-1:0]);
        return word_t'(v[WORD_W-1:0]);
    endfunction

    function automatic logic sat_hit(input sum_t v);
        return (v > SAT_HI) || (v < SAT_LO);
    endfunction

    function automatic sum_t ext(input prod_t p);
        return sum_t'(p);
    endfunction

endpackage

// ----- rtl/pft_inv.sv -----
// ----------------------------------------------------------------------------
// pft_inv
// reference quaternion inverse: squared norm, then serial restoring divides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pose_frame_transform_top_macros.svh"

module pft_inv (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  pft_pkg::ref_t ref_pose,
    output pft_pkg::inv_t inv
);
    import pft_pkg::*;

    typedef enum logic [2:0] {ST_IDLE, ST_NORM, ST_LOAD, ST_DIV, ST_STORE} state_t;

    state_t                state_reg, state_next;
    logic [1:0]            idx_reg, idx_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [NORM_W-1:0]     n_reg, n_next;
    logic [NORM_W-1:0]     rem_reg, rem_next;
    logic [DVD_W-1:0]      dvd_reg, dvd_next;
    logic                  neg_reg, neg_next;
    logic                  ovf_reg, ovf_next;
    word_t                 q_reg[4];
    word_t                 q_next[4];

    word_t                 qsel;
    logic signed [2*WORD_W-1:0] sq;
    logic [2*WORD_W-1:0]   sq_rnd;
    logic signed [WORD_W:0] comp;
    logic [WORD_W-1:0]     mag;
    logic [NORM_W:0]       rem_sh;
    logic [DVD_W-1:0]      r;
    logic                  r_big;
    word_t                 r_word;

    always_comb
    begin
        unique case (idx_reg)
            2'd0: qsel = ref_pose.quat_x;
            2'd1: qsel = ref_pose.quat_y;
            2'd2: qsel = ref_pose.quat_z;
            default: qsel = ref_pose.quat_w;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        for (int i = 0; i < 4; i++)
        begin
            q_next[i] = q_reg[i];
        end

        sq     = qsel * qsel;
        sq_rnd = (64'(sq) + (64'd1 << (QFRAC - 1))) >> QFRAC;
        comp   = (idx_reg == 2'd3) ? {qsel[WORD_W-1], qsel} : -{qsel[WORD_W-1], qsel};
        mag    = comp[WORD_W] ? WORD_W'(-comp) : comp[WORD_W-1:0];
        rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
        r      = dvd_reg;
        if (neg_reg)
        begin
            r_big  = r > DVD_W'(64'd2147483648);
            r_word = r_big ? word_t'(SAT_LO[WORD_W-1:0]) : word_t'(-r[WORD_W-1:0]);
        end
        else
        begin
            r_big  = r > DVD_W'(64'd2147483647);
            r_word = r_big ? word_t'(SAT_HI[WORD_W-1:0]) : word_t'(r[WORD_W-1:0]);
        end

        priority if (start)
        begin
            state_next = ST_NORM;
            idx_next   = 2'd0;
            n_next     = '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE: ;
                ST_NORM:
                begin
                    n_next   = n_reg + NORM_W'(sq_rnd);
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                    begin
                        ovf_next = 1'b0;
                        if (n_next == '0)
                        begin
                            // zero norm: inverse is all zero and flagged
                            ovf_next   = 1'b1;
                            state_next = ST_IDLE;
                            for (int i = 0; i < 4; i++)
                            begin
                                q_next[i] = '0;
                            end
                        end
                        else
                        begin
                            state_next = ST_LOAD;
                        end
                    end
                end
                ST_LOAD:
                begin
                    neg_next   = comp[WORD_W];
                    dvd_next   = (DVD_W'(mag) << QFRAC) + DVD_W'(n_reg >> 1);
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                ST_DIV:
                begin
                    if (rem_sh >= {1'b0, n_reg})
                    begin
                        rem_next = NORM_W'(rem_sh - {1'b0, n_reg});
                        dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh[NORM_W-1:0];
                        dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
                    end
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DVD_W - 1))
                    begin
                        state_next = ST_STORE;
                    end
                end
                ST_STORE:
                begin
                    q_next[idx_reg] = r_word;
                    ovf_next        = ovf_reg | r_big;
                    idx_next        = idx_reg + 2'd1;
                    state_next      = (idx_reg == 2'd3) ? ST_IDLE : ST_LOAD;
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            n_reg     <= '0;
            ovf_reg   <= 1'b0;
            q_reg[0]  <= '0;
            q_reg[1]  <= '0;
            q_reg[2]  <= '0;
            q_reg[3]  <= QUAT_ONE;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
            ovf_reg   <= ovf_next;
            for (int i = 0; i < 4; i++)
            begin
                q_reg[i] <= q_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        neg_reg <= neg_next;
    end

    assign inv.busy = (state_reg != ST_IDLE);
    assign inv.ovf  = ovf_reg;
    assign inv.x    = q_reg[0];
    assign inv.y    = q_reg[1];
    assign inv.z    = q_reg[2];
    assign inv.w    = q_reg[3];

    `PFT_ASSERT_NEXT(a_start_norm, clk, rst_n, start, state_reg == ST_NORM, "start did not begin norm")
    `PFT_ASSERT_NEXT(a_zero_norm, clk, rst_n, !start && state_reg == ST_NORM && idx_reg == 2'd3 && n_next == '0, ovf_reg && q_reg[3] == '0 && state_reg == ST_IDLE, "zero norm not flagged")

endmodule

// ----- rtl/pft_pipe.sv -----
// ----------------------------------------------------------------------------
// pft_pipe
// six stage datapath: capture, select, products, sums, products, sums and output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pose_frame_transform_top_macros.svh"

module pft_pipe (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_take,
    output logic           in_ready,
    input  logic           command,
    input  pft_pkg::word_t pos_x,
    input  pft_pkg::word_t pos_y,
    input  pft_pkg::word_t pos_z,
    input  pft_pkg::word_t orient_x,
    input  pft_pkg::word_t orient_y,
    input  pft_pkg::word_t orient_z,
    input  pft_pkg::word_t orient_w,
    input  pft_pkg::ref_t  ref_pose,
    input  pft_pkg::inv_t  inv,
    output logic           out_valid,
    input  logic           out_stall,
    output pft_pkg::word_t out_pos_x,
    output pft_pkg::word_t out_pos_y,
    output pft_pkg::word_t out_pos_z,
    output pft_pkg::word_t out_quat_x,
    output pft_pkg::word_t out_quat_y,
    output pft_pkg::word_t out_quat_z,
    output pft_pkg::word_t out_quat_w,
    output logic           overflow
);
    import pft_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    // stage 1: captured transfer
    logic  s1_cmd_reg;
    word_t s1_p_reg[3];
    word_t s1_q_reg[4];
    // stage 2: selected rotation, vector and offset
    word_t s2_rq_reg[4];
    word_t s2_v_reg[3];
    word_t s2_a_reg[3];
    word_t s2_q_reg[4];
    logic  s2_f_reg;
    // stage 3: first products
    prod_t s3_pv_reg[4][3];
    prod_t s3_pq_reg[4][4];
    word_t s3_rq_reg[4];
    word_t s3_a_reg[3];
    logic  s3_f_reg;
    // stage 4: sandwich half and output quaternion
    word_t s4_t_reg[4];
    word_t s4_oq_reg[4];
    word_t s4_rq_reg[4];
    word_t s4_a_reg[3];
    logic  s4_f_reg;
    // stage 5: second products
    prod_t s5_pt_reg[3][4];
    word_t s5_oq_reg[4];
    word_t s5_a_reg[3];
    logic  s5_f_reg;
    // stage 6: output register
    word_t s6_p_reg[3];
    word_t s6_q_reg[4];
    logic  s6_f_reg;

    word_t rp[3];
    word_t rq[4];
    word_t iq[4];
    word_t s2_rq_next[4];
    word_t s2_v_next[3];
    word_t s2_a_next[3];
    logic  s2_f_next;
    sum_t  dsum[3];
    sum_t  tsum[4];
    sum_t  qsum[4];
    sum_t  osum[3];
    logic  s4_f_next;
    logic  s6_f_next;

    assign rdy6 = !v6_reg || !out_stall;
    assign rdy5 = !v5_reg || rdy6;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_take;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
            if (rdy6) v6_reg <= v5_reg;
        end
    end

    // stage 2: pick forward or inverse frame
    always_comb
    begin
        rp[0] = ref_pose.pos_x;
        rp[1] = ref_pose.pos_y;
        rp[2] = ref_pose.pos_z;
        rq[0] = ref_pose.quat_x;
        rq[1] = ref_pose.quat_y;
        rq[2] = ref_pose.quat_z;
        rq[3] = ref_pose.quat_w;
        iq[0] = inv.x;
        iq[1] = inv.y;
        iq[2] = inv.z;
        iq[3] = inv.w;
        s2_f_next = s1_cmd_reg & inv.ovf;
        for (int i = 0; i < 4; i++)
        begin
            s2_rq_next[i] = s1_cmd_reg ? iq[i] : rq[i];
        end
        for (int i = 0; i < 3; i++)
        begin
            dsum[i] = sum_t'(s1_p_reg[i]) - sum_t'(rp[i]);
            if (s1_cmd_reg)
            begin
                s2_v_next[i] = sat_word(dsum[i]);
                s2_a_next[i] = '0;
                s2_f_next    = s2_f_next | sat_hit(dsum[i]);
            end
            else
            begin
                s2_v_next[i] = s1_p_reg[i];
                s2_a_next[i] = rp[i];
            end
        end
    end

    // stage 4: sums of first products
    always_comb
    begin
        tsum[0] = ext(s3_pv_reg[0][0]) + ext(s3_pv_reg[0][1]) - ext(s3_pv_reg[0][2]);
        tsum[1] = ext(s3_pv_reg[1][0]) + ext(s3_pv_reg[1][1]) - ext(s3_pv_reg[1][2]);
        tsum[2] = ext(s3_pv_reg[2][0]) + ext(s3_pv_reg[2][1]) - ext(s3_pv_reg[2][2]);
        tsum[3] = ext(s3_pv_reg[3][0]) + ext(s3_pv_reg[3][1]) + ext(s3_pv_reg[3][2]);
        qsum[0] = ext(s3_pq_reg[0][0]) + ext(s3_pq_reg[0][1]) + ext(s3_pq_reg[0][2])
                - ext(s3_pq_reg[0][3]);
        qsum[1] = ext(s3_pq_reg[1][0]) - ext(s3_pq_reg[1][1]) + ext(s3_pq_reg[1][2])
                + ext(s3_pq_reg[1][3]);
        qsum[2] = ext(s3_pq_reg[2][0]) + ext(s3_pq_reg[2][1]) - ext(s3_pq_reg[2][2])
                + ext(s3_pq_reg[2][3]);
        qsum[3] = ext(s3_pq_reg[3][0]) - ext(s3_pq_reg[3][1]) - ext(s3_pq_reg[3][2])
                - ext(s3_pq_reg[3][3]);
        s4_f_next = s3_f_reg;
        for (int i = 0; i < 4; i++)
        begin
            s4_f_next = s4_f_next | sat_hit(tsum[i]) | sat_hit(qsum[i]);
        end
    end

    // stage 6: second sums plus offset
    always_comb
    begin
        osum[0] = ext(s5_pt_reg[0][0]) + ext(s5_pt_reg[0][1]) + ext(s5_pt_reg[0][2])
                - ext(s5_pt_reg[0][3]) + sum_t'(s5_a_reg[0]);
        osum[1] = ext(s5_pt_reg[1][0]) + ext(s5_pt_reg[1][1]) + ext(s5_pt_reg[1][2])
                - ext(s5_pt_reg[1][3]) + sum_t'(s5_a_reg[1]);
        osum[2] = ext(s5_pt_reg[2][0]) + ext(s5_pt_reg[2][1]) + ext(s5_pt_reg[2][2])
                - ext(s5_pt_reg[2][3]) + sum_t'(s5_a_reg[2]);
        s6_f_next = s5_f_reg;
        for (int i = 0; i < 3; i++)
        begin
            s6_f_next = s6_f_next | sat_hit(osum[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_cmd_reg  <= command;
            s1_p_reg[0] <= pos_x;
            s1_p_reg[1] <= pos_y;
            s1_p_reg[2] <= pos_z;
            s1_q_reg[0] <= orient_x;
            s1_q_reg[1] <= orient_y;
            s1_q_reg[2] <= orient_z;
            s1_q_reg[3] <= orient_w;
        end
        if (rdy2)
        begin
            s2_rq_reg <= s2_rq_next;
            s2_v_reg  <= s2_v_next;
            s2_a_reg  <= s2_a_next;
            s2_q_reg  <= s1_q_reg;
            s2_f_reg  <= s2_f_next;
        end
        if (rdy3)
        begin
            // v * conj(q)
            s3_pv_reg[0][0] <= rmul(s2_v_reg[0], s2_rq_reg[3]);
            s3_pv_reg[0][1] <= rmul(s2_v_reg[2], s2_rq_reg[1]);
            s3_pv_reg[0][2] <= rmul(s2_v_reg[1], s2_rq_reg[2]);
            s3_pv_reg[1][0] <= rmul(s2_v_reg[1], s2_rq_reg[3]);
            s3_pv_reg[1][1] <= rmul(s2_v_reg[0], s2_rq_reg[2]);
            s3_pv_reg[1][2] <= rmul(s2_v_reg[2], s2_rq_reg[0]);
            s3_pv_reg[2][0] <= rmul(s2_v_reg[2], s2_rq_reg[3]);
            s3_pv_reg[2][1] <= rmul(s2_v_reg[1], s2_rq_reg[0]);
            s3_pv_reg[2][2] <= rmul(s2_v_reg[0], s2_rq_reg[1]);
            s3_pv_reg[3][0] <= rmul(s2_v_reg[0], s2_rq_reg[0]);
            s3_pv_reg[3][1] <= rmul(s2_v_reg[1], s2_rq_reg[1]);
            s3_pv_reg[3][2] <= rmul(s2_v_reg[2], s2_rq_reg[2]);
            // frame quaternion times pose quaternion
            s3_pq_reg[0][0] <= rmul(s2_rq_reg[3], s2_q_reg[0]);
            s3_pq_reg[0][1] <= rmul(s2_rq_reg[0], s2_q_reg[3]);
            s3_pq_reg[0][2] <= rmul(s2_rq_reg[1], s2_q_reg[2]);
            s3_pq_reg[0][3] <= rmul(s2_rq_reg[2], s2_q_reg[1]);
            s3_pq_reg[1][0] <= rmul(s2_rq_reg[3], s2_q_reg[1]);
            s3_pq_reg[1][1] <= rmul(s2_rq_reg[0], s2_q_reg[2]);
            s3_pq_reg[1][2] <= rmul(s2_rq_reg[1], s2_q_reg[3]);
            s3_pq_reg[1][3] <= rmul(s2_rq_reg[2], s2_q_reg[0]);
            s3_pq_reg[2][0] <= rmul(s2_rq_reg[3], s2_q_reg[2]);
            s3_pq_reg[2][1] <= rmul(s2_rq_reg[0], s2_q_reg[1]);
            s3_pq_reg[2][2] <= rmul(s2_rq_reg[1], s2_q_reg[0]);
            s3_pq_reg[2][3] <= rmul(s2_rq_reg[2], s2_q_reg[3]);
            s3_pq_reg[3][0] <= rmul(s2_rq_reg[3], s2_q_reg[3]);
            s3_pq_reg[3][1] <= rmul(s2_rq_reg[0], s2_q_reg[0]);
            s3_pq_reg[3][2] <= rmul(s2_rq_reg[1], s2_q_reg[1]);
            s3_pq_reg[3][3] <= rmul(s2_rq_reg[2], s2_q_reg[2]);
            s3_rq_reg <= s2_rq_reg;
            s3_a_reg  <= s2_a_reg;
            s3_f_reg  <= s2_f_reg;
        end
        if (rdy4)
        begin
            for (int i = 0; i < 4; i++)
            begin
                s4_t_reg[i]  <= sat_word(tsum[i]);
                s4_oq_reg[i] <= sat_word(qsum[i]);
            end
            s4_rq_reg <= s3_rq_reg;
            s4_a_reg  <= s3_a_reg;
            s4_f_reg  <= s4_f_next;
        end
        if (rdy5)
        begin
            // q * t, t = {tx, ty, tz, tw}
            s5_pt_reg[0][0] <= rmul(s4_rq_reg[3], s4_t_reg[0]);
            s5_pt_reg[0][1] <= rmul(s4_rq_reg[0], s4_t_reg[3]);
            s5_pt_reg[0][2] <= rmul(s4_rq_reg[1], s4_t_reg[2]);
            s5_pt_reg[0][3] <= rmul(s4_rq_reg[2], s4_t_reg[1]);
            s5_pt_reg[1][0] <= rmul(s4_rq_reg[3], s4_t_reg[1]);
            s5_pt_reg[1][1] <= rmul(s4_rq_reg[1], s4_t_reg[3]);
            s5_pt_reg[1][2] <= rmul(s4_rq_reg[2], s4_t_reg[0]);
            s5_pt_reg[1][3] <= rmul(s4_rq_reg[0], s4_t_reg[2]);
            s5_pt_reg[2][0] <= rmul(s4_rq_reg[3], s4_t_reg[2]);
            s5_pt_reg[2][1] <= rmul(s4_rq_reg[2], s4_t_reg[3]);
            s5_pt_reg[2][2] <= rmul(s4_rq_reg[0], s4_t_reg[1]);
            s5_pt_reg[2][3] <= rmul(s4_rq_reg[1], s4_t_reg[0]);
            s5_oq_reg <= s4_oq_reg;
            s5_a_reg  <= s4_a_reg;
            s5_f_reg  <= s4_f_reg;
        end
        if (rdy6)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s6_p_reg[i] <= sat_word(osum[i]);
            end
            s6_q_reg <= s5_oq_reg;
            s6_f_reg <= s6_f_next;
        end
    end

    assign out_valid  = v6_reg;
    assign out_pos_x  = s6_p_reg[0];
    assign out_pos_y  = s6_p_reg[1];
    assign out_pos_z  = s6_p_reg[2];
    assign out_quat_x = s6_q_reg[0];
    assign out_quat_y = s6_q_reg[1];
    assign out_quat_z = s6_q_reg[2];
    assign out_quat_w = s6_q_reg[3];
    assign overflow   = s6_f_reg;

    `PFT_ASSERT_NEXT(a_mid_hold, clk, rst_n, v3_reg && !rdy3, v3_reg, "stalled stage lost its item")
    `PFT_ASSERT_NOW(a_stall_chain, clk, rst_n, !rdy1, v1_reg && v2_reg && v3_reg && v6_reg && out_stall, "stall without full pipe")

endmodule

// ----- rtl/pose_frame_transform_top.sv -----
// ----------------------------------------------------------------------------
// pose_frame_transform_top
// composes an input pose with a reference pose held in apb registers
// ----------------------------------------------------------------------------
// input channel pose_valid / pose_stall carries command plus a pose; a transfer
// happens on a clock edge with valid high and stall low. results leave on
// result_valid / result_stall with the same rule, one result per input.
// result_valid rises once the pose has reached the last of the six register
// stages, and the result transfer can follow; one pose can be taken every cycle
// while no stall from the output or from the inverse unit holds the pipe.
// the output register and per-stage valids let the pipe keep filling while a
// result waits; when result_stall holds, stages back up and pose_stall rises
// once every stage is occupied. nothing is dropped or duplicated.
// the reference pose is written over apb (seven 32-bit registers at 4*i).
// each write to a reference quaternion register starts the inverse unit, which
// holds pose_stall high while busy: four norm steps, then, for a nonzero norm,
// for each of four components a load, a 62-step restoring divide and a store.
// reset gives the identity frame with its inverse ready, so poses are taken
// right after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pose_frame_transform_top_macros.svh"

module pose_frame_transform_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pft_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       pose_valid,
    output logic                       pose_stall,
    input  logic                       command,
    input  pft_pkg::word_t             pos_x,
    input  pft_pkg::word_t             pos_y,
    input  pft_pkg::word_t             pos_z,
    input  pft_pkg::word_t             orient_x,
    input  pft_pkg::word_t             orient_y,
    input  pft_pkg::word_t             orient_z,
    input  pft_pkg::word_t             orient_w,
    output logic                       result_valid,
    input  logic                       result_stall,
    output pft_pkg::word_t             out_pos_x,
    output pft_pkg::word_t             out_pos_y,
    output pft_pkg::word_t             out_pos_z,
    output pft_pkg::word_t             out_quat_x,
    output pft_pkg::word_t             out_quat_y,
    output pft_pkg::word_t             out_quat_z,
    output pft_pkg::word_t             out_quat_w,
    output logic                       overflow
);
    import pft_pkg::*;

    ref_t     ref_reg, ref_next;
    inv_t     inv;
    logic     wr_en;
    logic     inv_start;
    logic     pipe_ready;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        ref_next  = ref_reg;
        inv_start = 1'b0;
        if (wr_en && paddr[ADDR_W-1:2] != 3'd7)
        begin
            unique case (idx)
                REG_POS_X:  ref_next.pos_x  = word_t'(pwdata);
                REG_POS_Y:  ref_next.pos_y  = word_t'(pwdata);
                REG_POS_Z:  ref_next.pos_z  = word_t'(pwdata);
                REG_QUAT_X: ref_next.quat_x = word_t'(pwdata);
                REG_QUAT_Y: ref_next.quat_y = word_t'(pwdata);
                REG_QUAT_Z: ref_next.quat_z = word_t'(pwdata);
                REG_QUAT_W: ref_next.quat_w = word_t'(pwdata);
                default: ;
            endcase
            inv_start = (idx == REG_QUAT_X) || (idx == REG_QUAT_Y)
                     || (idx == REG_QUAT_Z) || (idx == REG_QUAT_W);
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_POS_X:  prdata = ref_reg.pos_x;
            REG_POS_Y:  prdata = ref_reg.pos_y;
            REG_POS_Z:  prdata = ref_reg.pos_z;
            REG_QUAT_X: prdata = ref_reg.quat_x;
            REG_QUAT_Y: prdata = ref_reg.quat_y;
            REG_QUAT_Z: prdata = ref_reg.quat_z;
            REG_QUAT_W: prdata = ref_reg.quat_w;
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // identity frame: zero offset, w = 1.0
            ref_reg <= ref_t'({{(6 * WORD_W){1'b0}}, QUAT_ONE});
        end
        else
        begin
            ref_reg <= ref_next;
        end
    end

    assign pose_stall = !pipe_ready || inv.busy;

    pft_inv u_inv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (inv_start),
        .ref_pose (ref_reg),
        .inv      (inv)
    );

    pft_pipe u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_take    (pose_valid && !inv.busy),
        .in_ready   (pipe_ready),
        .command    (command),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .orient_x   (orient_x),
        .orient_y   (orient_y),
        .orient_z   (orient_z),
        .orient_w   (orient_w),
        .ref_pose   (ref_reg),
        .inv        (inv),
        .out_valid  (result_valid),
        .out_stall  (result_stall),
        .out_pos_x  (out_pos_x),
        .out_pos_y  (out_pos_y),
        .out_pos_z  (out_pos_z),
        .out_quat_x (out_quat_x),
        .out_quat_y (out_quat_y),
        .out_quat_z (out_quat_z),
        .out_quat_w (out_quat_w),
        .overflow   (overflow)
    );

    `PFT_ASSERT_NOW(a_busy_stalls, clk, rst_n, inv.busy, pose_stall, "pose taken while inverse busy")
    `PFT_ASSERT_NEXT(a_quat_write_busy, clk, rst_n, inv_start, inv.busy, "quaternion write did not start inverse")

endmodule

// ----- verif/pft_checker.sv -----
// ----------------------------------------------------------------------------
// pft_checker
// watches the apb port and both pose channels, predicts each composed pose
// from its own copy of the reference registers and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pft_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [pft_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    input  logic                       pose_valid,
    input  logic                       pose_stall,
    input  logic                       command,
    input  pft_pkg::word_t             pos_x,
    input  pft_pkg::word_t             pos_y,
    input  pft_pkg::word_t             pos_z,
    input  pft_pkg::word_t             orient_x,
    input  pft_pkg::word_t             orient_y,
    input  pft_pkg::word_t             orient_z,
    input  pft_pkg::word_t             orient_w,
    input  logic                       result_valid,
    input  logic                       result_stall,
    input  pft_pkg::word_t             out_pos_x,
    input  pft_pkg::word_t             out_pos_y,
    input  pft_pkg::word_t             out_pos_z,
    input  pft_pkg::word_t             out_quat_x,
    input  pft_pkg::word_t             out_quat_y,
    input  pft_pkg::word_t             out_quat_z,
    input  pft_pkg::word_t             out_quat_w,
    input  logic                       overflow,
    output int                         pending,
    output int                         errors
);
    import pft_pkg::*;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    typedef struct {
        word_t w[7];
        logic  ovf;
    } pose_result_t;

    word_t        ref_regs[NUM_REGS];
    pose_result_t expected_poses[$];
    logic         sat_flag;
    string        field_name[7] = '{"pos_x", "pos_y", "pos_z",
                                    "quat_x", "quat_y", "quat_z", "quat_w"};

    assign pending = expected_poses.size();

    // rounded to nearest, ties toward +inf
    function automatic longint mulr(input longint a, input longint b);
        longint p;
        p = a * b + (64'sd1 <<< (QFRAC - 1));
        return p >>> QFRAC;
    endfunction

    function automatic longint clip(input longint v);
        if (v > WORD_MAX)
        begin
            sat_flag = 1'b1;
            return WORD_MAX;
        end
        if (v < WORD_MIN)
        begin
            sat_flag = 1'b1;
            return WORD_MIN;
        end
        return v;
    endfunction

    // sandwich rotation q v q*, two stages
    function automatic void spin(input longint q[4], input longint v[3],
                                 output longint o[3]);
        longint tx, ty, tz, tw;
        tx = clip(mulr(v[0], q[3]) + mulr(v[2], q[1]) - mulr(v[1], q[2]));
        ty = clip(mulr(v[1], q[3]) + mulr(v[0], q[2]) - mulr(v[2], q[0]));
        tz = clip(mulr(v[2], q[3]) + mulr(v[1], q[0]) - mulr(v[0], q[1]));
        tw = clip(mulr(v[0], q[0]) + mulr(v[1], q[1]) + mulr(v[2], q[2]));
        o[0] = mulr(q[3], tx) + mulr(q[0], tw) + mulr(q[1], tz) - mulr(q[2], ty);
        o[1] = mulr(q[3], ty) + mulr(q[1], tw) + mulr(q[2], tx) - mulr(q[0], tz);
        o[2] = mulr(q[3], tz) + mulr(q[2], tw) + mulr(q[0], ty) - mulr(q[1], tx);
    endfunction

    function automatic void hamilton(input longint a[4], input longint b[4],
                                     output longint o[4]);
        o[0] = clip(mulr(a[3], b[0]) + mulr(a[0], b[3]) + mulr(a[1], b[2])
                    - mulr(a[2], b[1]));
        o[1] = clip(mulr(a[3], b[1]) - mulr(a[0], b[2]) + mulr(a[1], b[3])
                    + mulr(a[2], b[0]));
        o[2] = clip(mulr(a[3], b[2]) + mulr(a[0], b[1]) - mulr(a[1], b[0])
                    + mulr(a[2], b[3]));
        o[3] = clip(mulr(a[3], b[3]) - mulr(a[0], b[0]) - mulr(a[1], b[1])
                    - mulr(a[2], b[2]));
    endfunction

    // conjugate over squared norm, zero norm gives zero
    function automatic void invert(input longint q[4], output longint o[4]);
        longint n;
        longint c;
        longint unsigned mag;
        longint r;
        n = 0;
        for (int i = 0; i < 4; i++)
            n += mulr(q[i], q[i]);
        if (n <= 0)
        begin
            sat_flag = 1'b1;
            for (int i = 0; i < 4; i++)
                o[i] = 0;
            return;
        end
        for (int i = 0; i < 4; i++)
        begin
            c = (i < 3) ? -q[i] : q[i];
            mag = longint'(c < 0 ? -c : c) << QFRAC;
            r = longint'((mag + longint'(unsigned'(n)) / 2) / longint'(unsigned'(n)));
            o[i] = clip(c < 0 ? -r : r);
        end
    endfunction

    function automatic pose_result_t compose_pose(input logic cmd, input longint p[3],
                                                 input longint q[4]);
        pose_result_t res;
        longint rp[3], rq[4], rot[3], oq[4], inv[4], d[3];
        sat_flag = 1'b0;
        for (int i = 0; i < 3; i++)
            rp[i] = longint'(ref_regs[i]);
        for (int i = 0; i < 4; i++)
            rq[i] = longint'(ref_regs[3 + i]);
        if (!cmd)
        begin
            spin(rq, p, rot);
            for (int i = 0; i < 3; i++)
                res.w[i] = word_t'(clip(rot[i] + rp[i]));
            hamilton(rq, q, oq);
        end
        else
        begin
            invert(rq, inv);
            hamilton(inv, q, oq);
            for (int i = 0; i < 3; i++)
                d[i] = clip(p[i] - rp[i]);
            spin(inv, d, rot);
            for (int i = 0; i < 3; i++)
                res.w[i] = word_t'(clip(rot[i]));
        end
        for (int i = 0; i < 4; i++)
            res.w[3 + i] = word_t'(oq[i]);
        res.ovf = sat_flag;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        longint       p[3], q[4];
        word_t        got[7];
        pose_result_t exp_pose;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                ref_regs[i] = '0;
            ref_regs[REG_QUAT_W] = QUAT_ONE;
            expected_poses.delete();
            errors = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[4:2] < NUM_REGS)
                ref_regs[paddr[4:2]] = word_t'(pwdata);
            if (pose_valid && !pose_stall)
            begin
                p = '{longint'(pos_x), longint'(pos_y), longint'(pos_z)};
                q = '{longint'(orient_x), longint'(orient_y),
                      longint'(orient_z), longint'(orient_w)};
                expected_poses.push_back(compose_pose(command, p, q));
            end
            if (result_valid && !result_stall)
            begin
                got = '{out_pos_x, out_pos_y, out_pos_z,
                        out_quat_x, out_quat_y, out_quat_z, out_quat_w};
                if (expected_poses.size() == 0)
                begin
                    $display("%0t: result transfer with no pose pending", $time);
                    errors++;
                end
                else
                begin
                    exp_pose = expected_poses.pop_front();
                    for (int i = 0; i < 7; i++)
                        if (got[i] !== exp_pose.w[i])
                        begin
                            $display("%0t: %s expected %0d actual %0d", $time,
                                     field_name[i], exp_pose.w[i], got[i]);
                            errors++;
                        end
                    if (overflow !== exp_pose.ovf)
                    begin
                        $display("%0t: overflow expected %0b actual %0b", $time,
                                 exp_pose.ovf, overflow);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// drives poses and reference frames into the pose frame transform, with
// random idling on both channels, and reports the checker's verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import pft_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              pose_valid = 1'b0;
    logic              pose_stall;
    logic              command = 1'b0;
    word_t             pos_x = '0, pos_y = '0, pos_z = '0;
    word_t             orient_x = '0, orient_y = '0, orient_z = '0, orient_w = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    word_t             out_pos_x, out_pos_y, out_pos_z;
    word_t             out_quat_x, out_quat_y, out_quat_z, out_quat_w;
    logic              overflow;
    int                pending;
    int                errors;
    logic              quiet = 1'b0;
    int                hold_req = 0;
    int                cycles = 0;

    pose_frame_transform_top dut (.*);

    pft_checker chk (
        .clk, .rst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .pose_valid, .pose_stall, .command, .pos_x, .pos_y, .pos_z,
        .orient_x, .orient_y, .orient_z, .orient_w,
        .result_valid, .result_stall, .out_pos_x, .out_pos_y, .out_pos_z,
        .out_quat_x, .out_quat_y, .out_quat_z, .out_quat_w, .overflow,
        .pending, .errors
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** pose_frame_transform_top: FAILED **");
            $finish;
        end
    end

    // receiver side: random stalls plus a long hold-off on request
    always @(negedge clk)
    begin
        static int hold_seen = 0;
        static int hold_left = 0;
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = 150;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= !quiet && $urandom_range(0, 99) < 7;
    end

    task automatic reg_write(input reg_idx_t r, input word_t v);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = ADDR_W'(r) << 2;
        pwdata = v;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_frame(input word_t px, input word_t py, input word_t pz,
                             input word_t qx, input word_t qy, input word_t qz,
                             input word_t qw);
        // let the pipe drain before touching the registers
        wait (pending == 0);
        repeat (12) @(posedge clk);
        reg_write(REG_POS_X, px);
        reg_write(REG_POS_Y, py);
        reg_write(REG_POS_Z, pz);
        reg_write(REG_QUAT_X, qx);
        reg_write(REG_QUAT_Y, qy);
        reg_write(REG_QUAT_Z, qz);
        reg_write(REG_QUAT_W, qw);
    endtask

    task automatic send_pose(input logic cmd, input word_t px, input word_t py,
                             input word_t pz, input word_t qx, input word_t qy,
                             input word_t qz, input word_t qw);
        int gap;
        if (!quiet && $urandom_range(0, 99) < 7)
        begin
            gap = $urandom_range(1, 4);
            pose_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        command = cmd;
        pos_x = px;
        pos_y = py;
        pos_z = pz;
        orient_x = qx;
        orient_y = qy;
        orient_z = qz;
        orient_w = qw;
        pose_valid = 1'b1;
        do
            @(posedge clk);
        while (pose_stall);
        @(negedge clk);
    endtask

    function automatic word_t rand_word();
        case ($urandom_range(0, 3))
            0: return word_t'($urandom);
            1, 2: return word_t'($signed($urandom) >>> $urandom_range(2, 20));
            default:
                case ($urandom_range(0, 4))
                    0: return word_t'(32'h7fffffff);
                    1: return word_t'(32'h80000000);
                    2: return '0;
                    3: return QUAT_ONE;
                    default: return word_t'(-1);
                endcase
        endcase
    endfunction

    // mostly quaternion parts in +-0.5 and modest positions, some full range
    task automatic send_random(input int count);
        word_t q[4];
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                for (int i = 0; i < 4; i++)
                    q[i] = word_t'($signed($urandom) >>> 2);
                send_pose($urandom_range(0, 1),
                          word_t'($signed($urandom) >>> $urandom_range(4, 12)),
                          word_t'($signed($urandom) >>> $urandom_range(4, 12)),
                          word_t'($signed($urandom) >>> $urandom_range(4, 12)),
                          q[0], q[1], q[2], q[3]);
            end
            else
                send_pose($urandom_range(0, 1), rand_word(), rand_word(), rand_word(),
                          rand_word(), rand_word(), rand_word(), rand_word());
        end
        pose_valid = 1'b0;
    endtask

    localparam word_t WMAX = word_t'(32'h7fffffff);
    localparam word_t WMIN = word_t'(32'h80000000);
    localparam word_t HALF = word_t'(32'h20000000);

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // identity frame from reset, both commands, field extremes
        send_pose(1'b0, '0, '0, '0, '0, '0, '0, QUAT_ONE);
        send_pose(1'b1, WMAX, WMIN, 32'sd65536, '0, '0, '0, QUAT_ONE);
        send_pose(1'b0, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX);
        send_pose(1'b1, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN);
        send_pose(1'b0, word_t'(-1), 32'sd1, word_t'(-1), 32'sd1, word_t'(-1), 32'sd1,
                  word_t'(-1));
        send_pose(1'b1, 32'sd1, word_t'(-1), 32'sd1, HALF, HALF, HALF, HALF);
        pose_valid = 1'b0;

        // offset frame with a 90 degree turn, position sum saturating
        set_frame(WMAX, WMIN, 32'sd65536, '0, '0, 32'sd759250125, 32'sd759250125);
        send_pose(1'b0, 32'sd100, 32'sd100, 32'sd100, '0, '0, '0, QUAT_ONE);
        send_pose(1'b1, WMIN, WMAX, '0, HALF, HALF, HALF, HALF);
        send_pose(1'b0, WMAX, WMAX, WMAX, WMIN, WMIN, WMIN, WMIN);
        send_pose(1'b1, 32'sd65536, 32'sd65536, 32'sd65536, '0, '0, '0, QUAT_ONE);
        pose_valid = 1'b0;

        // zero norm reference: inverse is all zero and flags overflow
        set_frame(32'sd5, word_t'(-5), '0, '0, '0, '0, '0);
        send_pose(1'b1, 32'sd1000, 32'sd2000, 32'sd3000, HALF, HALF, HALF, HALF);
        send_pose(1'b0, 32'sd1000, 32'sd2000, 32'sd3000, HALF, HALF, HALF, HALF);
        send_pose(1'b1, WMIN, WMIN, WMIN, '0, '0, '0, QUAT_ONE);
        send_random(60);

        // tiny reference quaternion: squared norm rounds to zero, inverse all zero
        set_frame('0, '0, '0, 32'sd1, '0, '0, 32'sd20000);
        send_pose(1'b1, 32'sd7, 32'sd7, 32'sd7, '0, '0, '0, QUAT_ONE);
        send_random(60);

        // extreme register values
        set_frame(WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX);
        send_random(60);
        set_frame(WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN);
        send_random(60);

        // near unit frame, receiver holds off so the pipe fills and stalls
        set_frame(word_t'($signed($urandom) >>> 8), word_t'($signed($urandom) >>> 8),
                  word_t'($signed($urandom) >>> 8), HALF, word_t'(-HALF), HALF, HALF);
        hold_req = hold_req + 1;
        send_random(100);

        // no idling on either side
        quiet = 1'b1;
        send_random(100);
        quiet = 1'b0;

        // full range random frames
        for (int ph = 0; ph < 3; ph++)
        begin
            set_frame(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                      rand_word(), rand_word());
            send_random(55);
        end

        wait (pending == 0);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("** pose_frame_transform_top: PASSED **");
        else
            $display("** pose_frame_transform_top: FAILED **");
        $finish;
    end

endmodule
